[hdl/cdwdt_pkg.sv]
// ----------------------------------------------------------------------------
// cdwdt_pkg
// Shared types and constants for the command-driven watchdog timer.
// ----------------------------------------------------------------------------
package cdwdt_pkg;

  // Reset values
  localparam logic [15:0] RELOAD_DEFAULT     = 16'd300;
  localparam logic        ARMED_DEFAULT      = 1'b0;
  localparam logic        POWER_DEFAULT      = 1'b0;
  localparam logic [15:0] RELOAD_MIN_RST     = 16'd10;
  localparam logic [15:0] RELOAD_MAX_RST     = 16'd600;
  localparam logic [15:0] RELOAD_STEP_RST    = 16'd10;
  localparam logic [6:0]  PERMIT_MASK_RST    = 7'h7F;
  localparam logic [15:0] LINK_IDLE_LIM_RST  = 16'd3000;
  localparam logic [15:0] FIRE_COUNT_MAX     = 16'hFFFF;

  // Config register indexes
  localparam logic [2:0] REG_RELOAD_MIN  = 3'd0;
  localparam logic [2:0] REG_RELOAD_MAX  = 3'd1;
  localparam logic [2:0] REG_RELOAD_STEP = 3'd2;
  localparam logic [2:0] REG_PERMIT_MASK = 3'd3;
  localparam logic [2:0] REG_LINK_LIMIT  = 3'd4;

  // Permit mask bit positions
  localparam int unsigned PERM_RELOAD = 0;
  localparam int unsigned PERM_FRESET = 1;
  localparam int unsigned PERM_FPOWER = 2;
  localparam int unsigned PERM_MODE   = 3;
  localparam int unsigned PERM_CLEAR  = 4;
  localparam int unsigned PERM_SELF   = 5;
  localparam int unsigned PERM_DISARM = 6;

  // Command characters
  localparam logic [7:0] CMD_FRESET  = 8'h46; // 'F'
  localparam logic [7:0] CMD_FPOWER  = 8'h50; // 'P'
  localparam logic [7:0] CMD_SELF    = 8'h23; // '#'
  localparam logic [7:0] CMD_LINK    = 8'h21; // '!'
  localparam logic [7:0] CMD_SHORTEN = 8'h2A; // '*'
  localparam logic [7:0] CMD_DISARM  = 8'h78; // 'x'
  localparam logic [7:0] CMD_ARM     = 8'h58; // 'X'
  localparam logic [7:0] CMD_KICK    = 8'h52; // 'R'
  localparam logic [7:0] CMD_CLEAR   = 8'h30; // '0'
  localparam logic [7:0] CMD_MODE_RST = 8'h6D; // 'm'
  localparam logic [7:0] CMD_MODE_PWR = 8'h4D; // 'M'
  localparam logic [7:0] CMD_DEC     = 8'h2D; // '-'
  localparam logic [7:0] CMD_INC     = 8'h2B; // '+'
  localparam logic [7:0] CMD_CONFIG  = 8'h43; // 'C'
  localparam logic [7:0] CMD_STATUS  = 8'h53; // 'S'
  localparam logic [7:0] CMD_VERSION = 8'h56; // 'V'
  localparam logic [7:0] CMD_FLIST   = 8'h51; // 'Q'
  localparam logic [7:0] CMD_HELP    = 8'h3F; // '?'

  typedef enum logic [3:0] {
    KIND_NONE      = 4'd0,
    KIND_STATUS    = 4'd1,
    KIND_FORBIDDEN = 4'd2,
    KIND_COUNTER   = 4'd3,
    KIND_MODE      = 4'd4,
    KIND_RELOAD    = 4'd5,
    KIND_VERSION   = 4'd6,
    KIND_CONFIG    = 4'd7,
    KIND_FLIST     = 4'd8,
    KIND_CLIST     = 4'd9,
    KIND_UNKNOWN   = 4'd10
  } reply_kind_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] cmd_byte;
  } in_item_t;

  typedef struct packed {
    reply_kind_e reply_kind;
    logic [7:0]  echo_byte;
    logic        target_reset_pulse;
    logic        target_power_pulse;
    logic        self_reboot_pulse;
    logic        link_reinit_pulse;
    logic        armed_now;
    logic        fired_now;
    logic [15:0] fire_count;
    logic [15:0] countdown_now;
    logic [15:0] reload_now;
    logic        power_mode_now;
  } out_item_t;

endpackage

[hdl/command_driven_watchdog_timer.sv]
// ----------------------------------------------------------------------------
// command_driven_watchdog_timer
// Watchdog driven by ticks and host command bytes, one result item per input.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | in        | in_valid_i / in_stall_o    | in_item_i  (mode, cmd_byte)
//  out     | out       | out_valid_o / out_stall_i  | out_item_o (reply + state)
//  cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
//  One item per cycle sustained while the output is not stalled. An item is
//  held in the input register, is decoded and applied to the watchdog state,
//  and its result lands in the output register on the same edge as the state update.
//  Reset loads the default state and config; no clearing pass is needed.
//  A stall at the output holds the result register; the input register keeps
//  accepting until it is full behind it, so in_stall_o rises once it is full.
//  Config writes are always taken (cfg_ready_o is tied high).
//
module command_driven_watchdog_timer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cdwdt_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cdwdt_pkg::out_item_t  out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);
  import cdwdt_pkg::*;

  // Config registers
  logic [15:0] reload_min_q, reload_max_q, reload_step_q, link_limit_q;
  logic [6:0]  permit_q;

  // Watchdog state
  logic [15:0] countdown_q, countdown_d;
  logic [15:0] reload_q, reload_d;
  logic        armed_q, armed_d;
  logic        fired_q, fired_d;
  logic [15:0] fire_total_q, fire_total_d;
  logic        power_mode_q, power_mode_d;
  logic [15:0] link_idle_q, link_idle_d;

  // Pipeline
  logic        s1_valid_q;
  in_item_t    s1_item_q;
  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;
  logic        s1_advance;

  assign cfg_ready_o = 1'b1;

  // s1 moves on when the output register is empty or being drained
  assign s1_advance = s1_valid_q & ~(out_valid_q & out_stall_i);
  assign in_stall_o = s1_valid_q & out_valid_q & out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // --------------------------------------------------------------------------
  // Config write port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_min_q  <= RELOAD_MIN_RST;
      reload_max_q  <= RELOAD_MAX_RST;
      reload_step_q <= RELOAD_STEP_RST;
      permit_q      <= PERMIT_MASK_RST;
      link_limit_q  <= LINK_IDLE_LIM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RELOAD_MIN:  reload_min_q  <= cfg_data_i;
        REG_RELOAD_MAX:  reload_max_q  <= cfg_data_i;
        REG_RELOAD_STEP: reload_step_q <= cfg_data_i;
        REG_PERMIT_MASK: permit_q      <= cfg_data_i[6:0];
        REG_LINK_LIMIT:  link_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Item decode and state update
  // --------------------------------------------------------------------------
  logic        gated;
  logic [2:0]  perm_idx;
  logic        denied;
  logic [16:0] inc_sum;
  logic [16:0] dec_raw;
  logic [16:0] step_raw;
  logic [16:0] clamp_lo;
  logic [15:0] clamped;
  logic        is_inc;

  // reload step and clamp: below min -> min, then at/above max -> max
  always_comb begin
    inc_sum = {1'b0, reload_q} + {1'b0, reload_step_q};
    dec_raw = (reload_q >= reload_step_q) ? {1'b0, reload_q - reload_step_q} : 17'd0;
    is_inc  = (s1_item_q.cmd_byte == CMD_INC);
    step_raw = is_inc ? inc_sum : dec_raw;
    clamp_lo = (step_raw < {1'b0, reload_min_q}) ? {1'b0, reload_min_q} : step_raw;
    clamped  = (clamp_lo >= {1'b0, reload_max_q}) ? reload_max_q : clamp_lo[15:0];
  end

  // which permit bit gates this command byte
  always_comb begin
    gated    = 1'b1;
    perm_idx = 3'(PERM_RELOAD);
    unique case (s1_item_q.cmd_byte)
      CMD_INC, CMD_DEC:         perm_idx = 3'(PERM_RELOAD);
      CMD_FRESET:               perm_idx = 3'(PERM_FRESET);
      CMD_FPOWER:               perm_idx = 3'(PERM_FPOWER);
      CMD_MODE_RST, CMD_MODE_PWR: perm_idx = 3'(PERM_MODE);
      CMD_CLEAR:                perm_idx = 3'(PERM_CLEAR);
      CMD_SELF:                 perm_idx = 3'(PERM_SELF);
      CMD_DISARM:               perm_idx = 3'(PERM_DISARM);
      default:                  gated    = 1'b0;
    endcase
    denied = gated & ~permit_q[perm_idx];
  end

  always_comb begin
    countdown_d  = countdown_q;
    reload_d     = reload_q;
    armed_d      = armed_q;
    fired_d      = fired_q;
    fire_total_d = fire_total_q;
    power_mode_d = power_mode_q;
    link_idle_d  = link_idle_q;

    out_item_d                    = '0;
    out_item_d.reply_kind         = KIND_NONE;

    if (!s1_item_q.mode) begin
      // time tick
      if (link_idle_q <= 16'd1) begin
        out_item_d.link_reinit_pulse = 1'b1;
        link_idle_d = link_limit_q;
      end else begin
        link_idle_d = link_idle_q - 16'd1;
      end
      if (armed_q) begin
        if (countdown_q == '0) begin
          if (power_mode_q) out_item_d.target_power_pulse = 1'b1;
          else              out_item_d.target_reset_pulse = 1'b1;
          armed_d = 1'b0;
          fired_d = 1'b1;
          if (fire_total_q != FIRE_COUNT_MAX) fire_total_d = fire_total_q + 16'd1;
        end else begin
          countdown_d = countdown_q - 16'd1;
        end
      end
    end else begin
      link_idle_d = link_limit_q;
      if (denied) begin
        out_item_d.reply_kind = KIND_FORBIDDEN;
        out_item_d.echo_byte  = s1_item_q.cmd_byte;
      end else begin
        unique case (s1_item_q.cmd_byte)
          CMD_FRESET: out_item_d.target_reset_pulse = 1'b1;
          CMD_FPOWER: out_item_d.target_power_pulse = 1'b1;
          CMD_SELF:   out_item_d.self_reboot_pulse  = 1'b1;
          CMD_LINK:   out_item_d.link_reinit_pulse  = 1'b1;
          CMD_SHORTEN: begin
            if (armed_q) countdown_d = reload_min_q;
            out_item_d.reply_kind = KIND_STATUS;
          end
          CMD_DISARM: begin
            if (armed_q) countdown_d = reload_q;
            armed_d = 1'b0;
            out_item_d.reply_kind = KIND_STATUS;
          end
          CMD_ARM: begin
            armed_d     = 1'b1;
            countdown_d = reload_q;
            fired_d     = 1'b0;
            out_item_d.reply_kind = KIND_STATUS;
          end
          CMD_KICK: begin
            if (armed_q) countdown_d = reload_q;
          end
          CMD_CLEAR: begin
            fire_total_d = '0;
            out_item_d.reply_kind = KIND_COUNTER;
          end
          CMD_MODE_RST: begin
            power_mode_d = 1'b0;
            out_item_d.reply_kind = KIND_MODE;
          end
          CMD_MODE_PWR: begin
            power_mode_d = 1'b1;
            out_item_d.reply_kind = KIND_MODE;
          end
          CMD_INC, CMD_DEC: begin
            reload_d = clamped;
            // kick uses the freshly stepped reload
            if (armed_q) countdown_d = clamped;
            out_item_d.reply_kind = KIND_RELOAD;
          end
          CMD_CONFIG:  out_item_d.reply_kind = KIND_CONFIG;
          CMD_STATUS:  out_item_d.reply_kind = KIND_STATUS;
          CMD_VERSION: out_item_d.reply_kind = KIND_VERSION;
          CMD_FLIST:   out_item_d.reply_kind = KIND_FLIST;
          CMD_HELP:    out_item_d.reply_kind = KIND_CLIST;
          default: begin
            out_item_d.reply_kind = KIND_UNKNOWN;
            out_item_d.echo_byte  = s1_item_q.cmd_byte;
          end
        endcase
      end
    end

    out_item_d.armed_now      = armed_d;
    out_item_d.fired_now      = fired_d;
    out_item_d.fire_count     = fire_total_d;
    out_item_d.countdown_now  = countdown_d;
    out_item_d.reload_now     = reload_d;
    out_item_d.power_mode_now = power_mode_d;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_q  <= RELOAD_DEFAULT;
      reload_q     <= RELOAD_DEFAULT;
      armed_q      <= ARMED_DEFAULT;
      fired_q      <= 1'b0;
      fire_total_q <= '0;
      power_mode_q <= POWER_DEFAULT;
      link_idle_q  <= LINK_IDLE_LIM_RST;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s1_advance) begin
        countdown_q  <= countdown_d;
        reload_q     <= reload_d;
        armed_q      <= armed_d;
        fired_q      <= fired_d;
        fire_total_q <= fire_total_d;
        power_mode_q <= power_mode_d;
        link_idle_q  <= link_idle_d;
      end
      if (!in_stall_o) s1_valid_q <= in_valid_i;
      if (!(out_valid_q && out_stall_i)) out_valid_q <= s1_valid_q;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) s1_item_q <= in_item_i;
    if (s1_advance) out_item_q <= out_item_d;
  end

endmodule
